// File: hdl/sparse_table_range_max_macros.svh
// Assertion macros shared by the sparse table range maximum RTL.
// Each macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef SPARSE_TABLE_RANGE_MAX_MACROS_SVH
`define SPARSE_TABLE_RANGE_MAX_MACROS_SVH

// The condition implies the expression in the same cycle.
`define STRM_CHECK(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// The condition implies the expression in the following cycle.
`define STRM_FOLLOW(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: hdl/strm_pkg.sv
// Shared types for the sparse table range maximum block.
// No dependencies.
`default_nettype none

package strm_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_BAD   = 2'd2
   } cmd_kind_type;

endpackage

`default_nettype wire

// File: hdl/strm_front.sv
// Front end: takes input beats, tracks the data set, and turns each beat into a command.
// Depends on strm_pkg; the command type comes in as a type parameter.
`default_nettype none

module strm_front
   import strm_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS = 11,
   parameter int VALUE_WIDTH = 32,
   parameter type cmd_type = logic
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_mode,
   input  logic [VALUE_WIDTH-1:0]          req_value,
   input  logic                            req_last,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] req_left,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] req_right,
   output cmd_type                         cmd_data,
   output logic                            cmd_push,
   input  logic                            cmd_full
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int LVL_W = $clog2(LEVELS);
   localparam int LEN_W = IDX_W + 1;

   logic                   hold_valid_ff, hold_valid_in;
   logic                   hold_mode_ff;
   logic [VALUE_WIDTH-1:0] hold_value_ff;
   logic                   hold_last_ff;
   logic [IDX_W-1:0]       hold_left_ff;
   logic [IDX_W-1:0]       hold_right_ff;
   logic                   hold_bad_ff;
   logic [LEN_W-1:0]       hold_len_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ready_ff, ready_in;

   logic                   accept;
   logic                   bad_now;
   logic [LEN_W-1:0]       len_now;
   logic [CNT_W-1:0]       base;
   logic                   store;
   logic [CNT_W-1:0]       new_count;
   logic [LVL_W-1:0]       level;
   logic [LEN_W-1:0]       span;
   logic [IDX_W-1:0]       index_b;

   function automatic logic [LVL_W-1:0] level_of(input logic [LEN_W-1:0] len);
      logic [LVL_W-1:0] lvl;
      lvl = '0;
      for (int k = 1; k < LEN_W; k++) begin
         if (len[k]) begin
            lvl = (k < LEVELS) ? LVL_W'(k) : LVL_W'(LEVELS - 1);
         end
      end
      return lvl;
   endfunction

   assign accept   = req_push && !hold_valid_ff;
   assign req_full = hold_valid_ff;
   assign cmd_push = hold_valid_ff && !cmd_full;

   assign bad_now = !ready_ff || (req_left > req_right) || (CNT_W'(req_right) >= count_ff);
   assign len_now = LEN_W'(req_right) - LEN_W'(req_left) + LEN_W'(1);

   assign base      = ready_ff ? '0 : count_ff;
   assign store     = base < CNT_W'(MAX_ELEMENTS);
   assign new_count = base + CNT_W'(store);
   assign level     = level_of(hold_len_ff);
   assign span      = LEN_W'(1) << level;
   assign index_b   = IDX_W'(LEN_W'(hold_right_ff) + LEN_W'(1) - span);

   always_comb begin
      cmd_data         = '0;
      cmd_data.kind    = hold_mode_ff ? (hold_bad_ff ? CMD_BAD : CMD_QUERY) : CMD_LOAD;
      cmd_data.store   = !hold_mode_ff && store;
      cmd_data.last    = !hold_mode_ff && hold_last_ff;
      cmd_data.value   = hold_value_ff;
      cmd_data.index_a = hold_mode_ff ? hold_left_ff : base[IDX_W-1:0];
      cmd_data.index_b = index_b;
      cmd_data.count   = new_count;
      cmd_data.level   = level;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      count_in      = count_ff;
      ready_in      = ready_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (cmd_push) begin
         hold_valid_in = 1'b0;
      end
      if (cmd_push && !hold_mode_ff) begin
         count_in = new_count;
         ready_in = hold_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         ready_ff      <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         count_ff      <= count_in;
         ready_ff      <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_mode_ff  <= req_mode;
         hold_value_ff <= req_value;
         hold_last_ff  <= req_last;
         hold_left_ff  <= req_left;
         hold_right_ff <= req_right;
         hold_bad_ff   <= bad_now;
         hold_len_ff   <= len_now;
      end
   end

endmodule

`default_nettype wire

// File: hdl/strm_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on the macros header; the entry type comes in as a type parameter.
`default_nettype none
`include "sparse_table_range_max_macros.svh"

module strm_cmd_queue #(
   parameter type cmd_type = logic
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] used_ff, used_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (used_ff == 2'd2);
   assign empty    = (used_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      used_in   = used_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `STRM_CHECK(empty_ptrs_meet, used_ff == 2'd0, wr_ptr_ff == rd_ptr_ff, "queue empty with pointers apart")

endmodule

`default_nettype wire

// File: hdl/strm_back.sv
// Back end: holds the sparse table memory, runs loads, the level build and queries.
// Depends on strm_pkg and the macros header; the command type comes in as a type parameter.
`default_nettype none
`include "sparse_table_range_max_macros.svh"

module strm_back
   import strm_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS = 11,
   parameter int VALUE_WIDTH = 32,
   parameter type cmd_type = logic
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd_data,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [VALUE_WIDTH-1:0] rsp_maximum,
   output logic                   rsp_status
);

   localparam int IDX_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int ADDR_W = LVL_W + IDX_W;
   localparam int SPAN_W = CNT_W + 1;
   localparam int DEPTH  = LEVELS * (2 ** IDX_W);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BUILD = 4'b0010,
      S_LEVEL = 4'b0100,
      S_QUERY = 4'b1000
   } state_type;

   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   state_type              state_ff, state_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic [ADDR_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [VALUE_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0] out_max_ff, out_max_in;
   logic                   out_status_ff, out_status_in;

   logic                   load_we;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
   logic [VALUE_WIDTH-1:0] pair_max;
   logic [LVL_W-1:0]       prev_lvl;
   logic [SPAN_W-1:0]      half_span;
   logic [SPAN_W-1:0]      span;
   logic [SPAN_W-1:0]      next_span;
   logic [LVL_W:0]         next_lvl;
   logic                   row_done;

   assign pair_max  = ($signed(rd_a_ff) >= $signed(rd_b_ff)) ? rd_a_ff : rd_b_ff;
   assign prev_lvl  = lvl_ff - LVL_W'(1);
   assign half_span = SPAN_W'(1) << prev_lvl;
   assign span      = SPAN_W'(1) << lvl_ff;
   assign next_span = SPAN_W'(2) << lvl_ff;
   assign next_lvl  = {1'b0, lvl_ff} + (LVL_W + 1)'(1);
   assign row_done  = (SPAN_W'(idx_ff) + SPAN_W'(1) + span) > SPAN_W'(cnt_ff);

   assign cmd_pop = (state_ff == S_IDLE) && !cmd_empty
                    && ((cmd_data.kind == CMD_LOAD) || !out_valid_ff);
   assign load_we = cmd_pop && (cmd_data.kind == CMD_LOAD) && cmd_data.store;

   assign mem_we    = load_we || pend_ff;
   assign mem_waddr = pend_ff ? pend_addr_ff : {LVL_W'(0), cmd_data.index_a};
   assign mem_wdata = pend_ff ? pair_max : cmd_data.value;

   always_comb begin
      if (state_ff == S_BUILD) begin
         rd_addr_a = {prev_lvl, idx_ff};
         rd_addr_b = {prev_lvl, IDX_W'(SPAN_W'(idx_ff) + half_span)};
      end else begin
         rd_addr_a = {cmd_data.level, cmd_data.index_a};
         rd_addr_b = {cmd_data.level, cmd_data.index_b};
      end
   end

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      out_valid_in  = (rsp_pop && out_valid_ff) ? 1'b0 : out_valid_ff;
      out_max_in    = out_max_ff;
      out_status_in = out_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               unique case (cmd_data.kind)
                  CMD_LOAD: begin
                     if (cmd_data.last && (cmd_data.count >= CNT_W'(2))) begin
                        state_in = S_BUILD;
                        lvl_in   = LVL_W'(1);
                        idx_in   = '0;
                        cnt_in   = cmd_data.count;
                     end
                  end
                  CMD_QUERY: begin
                     state_in = S_QUERY;
                  end
                  CMD_BAD: begin
                     out_valid_in  = 1'b1;
                     out_max_in    = '0;
                     out_status_in = 1'b1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_BUILD: begin
            pend_in      = 1'b1;
            pend_addr_in = {lvl_ff, idx_ff};
            if (row_done) begin
               state_in = S_LEVEL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_LEVEL: begin
            if ((next_lvl < (LVL_W + 1)'(LEVELS)) && (next_span <= SPAN_W'(cnt_ff))) begin
               state_in = S_BUILD;
               lvl_in   = lvl_ff + LVL_W'(1);
               idx_in   = '0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_QUERY: begin
            state_in      = S_IDLE;
            out_valid_in  = 1'b1;
            out_max_in    = pair_max;
            out_status_in = 1'b0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pend_addr_ff  <= pend_addr_in;
      out_max_ff    <= out_max_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_maximum = out_max_ff;
   assign rsp_status  = out_status_ff;

   `STRM_CHECK(query_slot_free, state_ff == S_QUERY, !out_valid_ff, "query read with result slot taken")
   `STRM_CHECK(no_write_clash, load_we, !pend_ff, "load write collides with build write")
   `STRM_FOLLOW(level_drained, state_ff == S_LEVEL, !pend_ff, "build write pending past level end")

endmodule

`default_nettype wire

// File: hdl/sparse_table_range_max.sv
// Top level of the sparse table range maximum block: front end, command queue, back end.
// Depends on strm_pkg, strm_front, strm_cmd_queue and strm_back.
//
//   Channel  Ports                                   Direction
//   req      push/full, mode value last left right   in
//   rsp      empty/pop, maximum status               out
//
// The front end registers each beat, classifies it against the loaded count and takes
// no new beat until the held one moves into the queue. In the back end a good query
// reads through two memory read ports with registered data. A load with the last flag
// then builds the table, one entry per cycle, passing through S_LEVEL after each level.
// Reset is synchronous and needs no clearing pass.
// While a result waits, loads still drain; queries stop at the queue head. Full is
// high while the front register holds a beat, which waits there while the queue is full.
`default_nettype none

module sparse_table_range_max
   import strm_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS = 11,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_mode,
   input  logic [VALUE_WIDTH-1:0]          req_value,
   input  logic                            req_last,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] req_left,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] req_right,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [VALUE_WIDTH-1:0]          rsp_maximum,
   output logic                            rsp_status
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int LVL_W = $clog2(LEVELS);

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   store;
      logic                   last;
      logic [VALUE_WIDTH-1:0] value;
      logic [IDX_W-1:0]       index_a;
      logic [IDX_W-1:0]       index_b;
      logic [CNT_W-1:0]       count;
      logic [LVL_W-1:0]       level;
   } cmd_type;

   cmd_type cmd_in;
   cmd_type cmd_head;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;

   strm_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS),
      .VALUE_WIDTH  (VALUE_WIDTH),
      .cmd_type     (cmd_type)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_mode  (req_mode),
      .req_value (req_value),
      .req_last  (req_last),
      .req_left  (req_left),
      .req_right (req_right),
      .cmd_data  (cmd_in),
      .cmd_push  (cmd_push),
      .cmd_full  (cmd_full)
   );

   strm_cmd_queue #(
      .cmd_type (cmd_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   strm_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS),
      .VALUE_WIDTH  (VALUE_WIDTH),
      .cmd_type     (cmd_type)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_data    (cmd_head),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_maximum (rsp_maximum),
      .rsp_status  (rsp_status)
   );

endmodule

`default_nettype wire

// File: test/tb_sparse_table_range_max.sv
`timescale 1ns / 100ps
// Self-checking testbench for sparse_table_range_max: loads data sets, sends range maximum
// queries and checks every response beat against a sparse table kept inside the bench.
// Depends only on the sparse_table_range_max RTL.

module tb_sparse_table_range_max;

   localparam int MAX_ELEMENTS = 1024;
   localparam int LEVELS = 11;
   localparam bit MODE_LOAD = 1'b0;
   localparam bit MODE_QUERY = 1'b1;
   localparam bit STATUS_OK = 1'b0;
   localparam bit STATUS_BAD_RANGE = 1'b1;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int SEND_IDLE [4] = '{0, 75, 0, 26};
   localparam int RSP_STALL [4] = '{0, 0, 75, 26};

   typedef struct packed {
      logic [31:0] maximum;
      logic        status;
   } answer_type;

   typedef struct packed {
      bit        mode;
      bit [31:0] value;
      bit        last_flag;
      bit [9:0]  lo;
      bit [9:0]  hi;
      bit        typed;
      bit [31:0] exp_max;
      bit        exp_status;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [23] = '{
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd0,    1'b1, 32'h0, STATUS_BAD_RANGE},
      '{MODE_LOAD,  32'h8000_0000, 1'b0, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd0,    1'b1, 32'h0, STATUS_BAD_RANGE},
      '{MODE_LOAD,  32'h7FFF_FFFF, 1'b1, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd1,    1'b1, 32'h7FFF_FFFF, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd0,    1'b1, 32'h8000_0000, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd1,    10'd0,    1'b1, 32'h0, STATUS_BAD_RANGE},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd2,    1'b1, 32'h0, STATUS_BAD_RANGE},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd1023, 10'd1023, 1'b1, 32'h0, STATUS_BAD_RANGE},
      '{MODE_LOAD,  32'hFFFF_FFFF, 1'b0, 10'd1023, 10'd1023, 1'b0, 32'h0, STATUS_OK},
      '{MODE_LOAD,  32'h0000_0005, 1'b0, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_LOAD,  32'hFFFF_FFF9, 1'b0, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_LOAD,  32'h0000_0003, 1'b0, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_LOAD,  32'h0000_0000, 1'b1, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd4,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd2,    10'd3,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'hFFFF_FFFF, 1'b1, 10'd1,    10'd4,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd4,    10'd4,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd2,    10'd4,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd5,    1'b1, 32'h0, STATUS_BAD_RANGE},
      '{MODE_LOAD,  32'h0000_002A, 1'b1, 10'd0,    10'd0,    1'b0, 32'h0, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd0,    1'b1, 32'h2A, STATUS_OK},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, 10'd0,    10'd1,    1'b1, 32'h0, STATUS_BAD_RANGE}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_mode = 1'b0;
   logic [31:0] req_value = '0;
   logic        req_last = 1'b0;
   logic [9:0]  req_left = '0;
   logic [9:0]  req_right = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_maximum;
   logic        rsp_status;

   logic signed [31:0] level_max [LEVELS][MAX_ELEMENTS];
   int         loaded_count = 0;
   bit         table_built = 1'b0;
   answer_type awaited_answers [$];

   int error_count = 0;
   int beats_sent = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_rsp = 1'b0;

   sparse_table_range_max uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .req_last    (req_last),
      .req_left    (req_left),
      .req_right   (req_right),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_maximum (rsp_maximum),
      .rsp_status  (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit predict_range_max(input bit mode, input logic [31:0] value,
                                            input bit last_flag, input logic [9:0] lo,
                                            input logic [9:0] hi, output answer_type ans);
      int lvl, i, half, len, q, span;
      logic signed [31:0] a, b;
      ans.maximum = '0;
      ans.status = STATUS_BAD_RANGE;
      if (mode == MODE_LOAD) begin
         if (table_built) begin
            loaded_count = 0;
            table_built = 1'b0;
         end
         if (loaded_count < MAX_ELEMENTS) begin
            level_max[0][loaded_count] = value;
            loaded_count++;
         end
         if (last_flag) begin
            for (lvl = 1; lvl < LEVELS; lvl++) begin
               half = 1 << (lvl - 1);
               if (2 * half > loaded_count) break;
               for (i = 0; i + 2 * half <= loaded_count; i++) begin
                  a = level_max[lvl - 1][i];
                  b = level_max[lvl - 1][i + half];
                  level_max[lvl][i] = (a >= b) ? a : b;
               end
            end
            table_built = 1'b1;
         end
         return 1'b0;
      end
      if (!table_built || lo > hi || int'(hi) >= loaded_count) return 1'b1;
      len = int'(hi) - int'(lo) + 1;
      q = 0;
      while (((len >> 1) >> q) != 0 && q + 1 < LEVELS) q++;
      span = 1 << q;
      a = level_max[q][lo];
      b = level_max[q][int'(hi) + 1 - span];
      ans.maximum = (a >= b) ? a : b;
      ans.status = STATUS_OK;
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic drive_beat(input bit mode, input logic [31:0] value, input bit last_flag,
                             input logic [9:0] lo, input logic [9:0] hi,
                             input bit typed = 1'b0, input logic [31:0] typed_max = '0,
                             input bit typed_status = 1'b0);
      answer_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      req_last <= last_flag;
      req_left <= lo;
      req_right <= hi;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (predict_range_max(mode, value, last_flag, lo, hi, ans)) begin
         if (typed) begin
            ans.maximum = typed_max;
            ans.status = typed_status;
         end
         awaited_answers = {awaited_answers, ans};
      end
      beats_sent++;
   endtask

   task automatic send_random_query();
      int r;
      logic [9:0] lo, hi;
      r = $urandom_range(99);
      lo = 10'($urandom);
      hi = 10'($urandom);
      if (table_built) begin
         if (r < 75) begin
            lo = 10'($urandom_range(loaded_count - 1));
            hi = 10'($urandom_range(loaded_count - 1, int'(lo)));
         end else if (r < 85 && loaded_count > 1) begin
            hi = 10'($urandom_range(loaded_count - 2));
            lo = 10'($urandom_range(loaded_count - 1, int'(hi) + 1));
         end else if (r < 93 && loaded_count < MAX_ELEMENTS) begin
            hi = 10'($urandom_range(MAX_ELEMENTS - 1, loaded_count));
         end
      end
      drive_beat(MODE_QUERY, $urandom, 1'($urandom_range(1)), lo, hi);
   endtask

   task automatic wait_for_answers();
      req_push <= 1'b0;
      @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed data sets of varied size followed by queries, with a few
   // queries slipped in while a set is still being loaded.
   task automatic run_random_sets(input int beat_goal);
      int first_beat, set_size, r, k;
      first_beat = beats_sent;
      while (beats_sent - first_beat < beat_goal) begin
         r = $urandom_range(99);
         if (r < 70) set_size = $urandom_range(1, 16);
         else if (r < 92) set_size = $urandom_range(17, 64);
         else if (r < 98) set_size = $urandom_range(65, 160);
         else set_size = $urandom_range(161, 300);
         for (k = 0; k < set_size; k++) begin
            if ($urandom_range(99) < 4) send_random_query();
            drive_beat(MODE_LOAD, pick_value(), k == set_size - 1,
                       10'($urandom), 10'($urandom));
         end
         repeat ($urandom_range(1, 12)) send_random_query();
      end
   endtask

   always begin : check_rsp_beats
      answer_type want;
      @(posedge clock);
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: response beat with nothing awaited: maximum %h status %0d",
                     $time, rsp_maximum, rsp_status);
            error_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_maximum !== want.maximum) begin
               $display("%0t: maximum expected %h actual %h", $time, want.maximum,
                        rsp_maximum);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
         end
      end
      if (hold_rsp) begin
         rsp_pop <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp = 1'b0;
      end
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("tb_sparse_table_range_max: errors");
         $finish;
      end
   end

   initial begin
      int n, p, k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (n = 0; n < 23; n++) begin
         drive_beat(DIRECTED_ROWS[n].mode, DIRECTED_ROWS[n].value, DIRECTED_ROWS[n].last_flag,
                    DIRECTED_ROWS[n].lo, DIRECTED_ROWS[n].hi, DIRECTED_ROWS[n].typed,
                    DIRECTED_ROWS[n].exp_max, DIRECTED_ROWS[n].exp_status);
      end
      wait_for_answers();
      for (p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         stall_pct = RSP_STALL[p];
         run_random_sets(ITEMS_PER_PHASE);
         if (p == 0) begin
            // The response side holds off while queries keep coming, so the input fills up.
            for (k = 0; k < 8; k++) begin
               drive_beat(MODE_LOAD, pick_value(), k == 7, 10'($urandom), 10'($urandom));
            end
            hold_rsp = 1'b1;
            repeat (40) send_random_query();
         end
         wait_for_answers();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_sparse_table_range_max: clean");
      end else begin
         $display("tb_sparse_table_range_max: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/strm_pkg.sv
hdl/strm_front.sv
hdl/strm_cmd_queue.sv
hdl/strm_back.sv
hdl/sparse_table_range_max.sv
test/tb_sparse_table_range_max.sv
